[src/rhpm_pkg.sv]
// Shared package of the rolling hash pattern matcher: widths, payload structs,
// register indexes and the command structs passed between the top and its units.
// No dependencies.
`timescale 1ns / 1ps

package rhpm_pkg;

  localparam int unsigned HASH_W          = 23;  // modulus and hash width
  localparam int unsigned RADIX_BITS      = 8;   // hash radix is 2**RADIX_BITS
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned PAT_BYTES       = 16;  // bytes held by the two pattern registers
  localparam int unsigned MAX_PATTERN_DEF = 16;
  localparam int unsigned LEN_W           = 5;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned COUNT_W         = 32;

  localparam logic [LEN_W-1:0]  LEN_RESET     = LEN_W'(1);
  localparam logic [HASH_W-1:0] MODULUS_RESET = HASH_W'(101);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2,
    REG_MODULUS  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              start_of_text;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] window_start;
    logic               hash_equal;
    logic               pattern_match;
    logic [COUNT_W-1:0] hit_count;
    logic               found_any;
  } out_item_t;

  // Command to the modular arithmetic unit. A multiply-accumulate computes
  // (acc * 2**RADIX_BITS + mult * addend) mod q; a subtract computes
  // (acc - addend) mod q.
  typedef struct packed {
    logic                  start;
    logic                  sub;
    logic [HASH_W-1:0]     acc;
    logic [RADIX_BITS-1:0] mult;
    logic [HASH_W-1:0]     addend;
  } modu_cmd_t;

  typedef struct packed {
    logic              clear;
    logic              shift;
    logic [BYTE_W-1:0] data;
  } win_cmd_t;

endpackage

[src/rhpm_modunit.sv]
// Shared modular arithmetic unit: bit-serial multiply-accumulate modulo q,
// one multiplier bit per cycle, plus a modular subtract that does not set busy.
// Depends on rhpm_pkg.
`timescale 1ns / 1ps

module rhpm_modunit import rhpm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  modu_cmd_t         cmd_i,
  input  logic [HASH_W-1:0] q_i,
  output logic [HASH_W-1:0] res_o,
  output logic              busy_o
);

  localparam int unsigned CNT_W = $clog2(RADIX_BITS + 1);

  logic [HASH_W-1:0]     r_q, r_d;
  logic [HASH_W-1:0]     a_q, a_d;
  logic [RADIX_BITS-1:0] x_q, x_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;

  logic [HASH_W+1:0] v;
  logic [HASH_W+1:0] q1;
  logic [HASH_W+1:0] q2;
  logic [HASH_W+1:0] v_red;
  logic [HASH_W:0]   diff;

  // One step: r = (2r + bit * a) mod q. The sum is below 3q, so both
  // candidate corrections are compared side by side.
  always_comb begin
    q1 = {2'b00, q_i};
    q2 = {1'b0, q_i, 1'b0};
    v  = {1'b0, r_q, 1'b0} + (x_q[RADIX_BITS-1] ? {2'b00, a_q} : '0);
    if (v >= q2) begin
      v_red = v - q2;
    end else if (v >= q1) begin
      v_red = v - q1;
    end else begin
      v_red = v;
    end
    if (cmd_i.acc >= cmd_i.addend) begin
      diff = {1'b0, cmd_i.acc} - {1'b0, cmd_i.addend};
    end else begin
      diff = {1'b0, cmd_i.acc} + {1'b0, q_i} - {1'b0, cmd_i.addend};
    end
  end

  always_comb begin
    r_d    = r_q;
    a_d    = a_q;
    x_d    = x_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (cmd_i.start) begin
      if (cmd_i.sub) begin
        r_d = diff[HASH_W-1:0];
      end else begin
        r_d    = cmd_i.acc;
        a_d    = cmd_i.addend;
        x_d    = cmd_i.mult;
        cnt_d  = CNT_W'(RADIX_BITS);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      r_d   = v_red[HASH_W-1:0];
      x_d   = {x_q[RADIX_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q    <= '0;
      a_q    <= '0;
      x_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      r_q    <= r_d;
      a_q    <= a_d;
      x_q    <= x_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  assign res_o  = r_q;
  assign busy_o = busy_q;

endmodule

[src/rhpm_window.sv]
// Text window shift register with the exact pattern comparison and the
// selection of the byte that leaves the hash window.
// Depends on rhpm_pkg.
`timescale 1ns / 1ps

module rhpm_window import rhpm_pkg::*; #(
  parameter int unsigned MaxPattern = MAX_PATTERN_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  win_cmd_t                           cmd_i,
  input  logic [$clog2(MaxPattern+1)-1:0]    len_i,
  input  logic [BYTE_W-1:0]                  pat_i [MaxPattern],
  output logic [BYTE_W-1:0]                  tail_o,
  output logic                               match_o
);

  localparam int unsigned KW   = $clog2(MaxPattern + 1);
  localparam int unsigned IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  // Entry 0 holds the newest byte.
  logic [BYTE_W-1:0] win_q [MaxPattern];
  logic [BYTE_W-1:0] win_d [MaxPattern];

  logic [KW-1:0] tidx;
  logic [KW-1:0] pidx;

  always_comb begin
    win_d = win_q;
    if (cmd_i.clear) begin
      for (int unsigned j = 0; j < MaxPattern; j++) begin
        win_d[j] = '0;
      end
    end else if (cmd_i.shift) begin
      win_d[0] = cmd_i.data;
      for (int unsigned j = 1; j < MaxPattern; j++) begin
        win_d[j] = win_q[j-1];
      end
    end
  end

  // The window byte j bytes back lines up with pattern byte len-1-j.
  always_comb begin
    tidx    = len_i - KW'(1);
    tail_o  = win_q[tidx[IdxW-1:0]];
    pidx    = '0;
    match_o = 1'b1;
    for (int unsigned j = 0; j < MaxPattern; j++) begin
      pidx = len_i - KW'(1) - KW'(j);
      if ((KW'(j) < len_i) && (win_q[j] != pat_i[pidx[IdxW-1:0]])) begin
        match_o = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned j = 0; j < MaxPattern; j++) begin
        win_q[j] <= '0;
      end
    end else begin
      win_q <= win_d;
    end
  end

endmodule

[src/rolling_hash_pattern_matcher.sv]
// Rolling hash pattern matcher top level: configuration registers, sequencer,
// text counters and result register. Uses rhpm_modunit and rhpm_window.
// Depends on rhpm_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        sink       in_valid_i/in_stall_o   in_item_t  (text byte, start of text)
// out       source     out_valid_o/out_stall_i out_item_t (window result)
// cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Sequence: each byte takes two 8-step multiply-accumulates of the shared unit
// once the window is full, for the weight of the leaving byte and then for the
// new byte, with a subtract between them, and one while it fills. A register
// write rederives the pattern hash and leading power over the pattern bytes.
// Reset: asynchronous, active low; the state after reset needs no rederive.
// Stalls: a finished result waits in the output register; the next byte may
// be taken meanwhile and only its result step waits for the register to free.

module rolling_hash_pattern_matcher import rhpm_pkg::*; #(
  parameter int unsigned MaxPattern = MAX_PATTERN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned KW   = $clog2(MaxPattern + 1);
  localparam int unsigned IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ITEM,
    S_DROP_WAIT,
    S_SUB_WAIT,
    S_UPD_WAIT,
    S_CHECK,
    S_DER_INIT,
    S_DER_P,
    S_DER_P_WAIT,
    S_DER_H,
    S_DER_H_WAIT
  } state_e;

  state_e                 state_q, state_d;
  logic [CFG_DATA_W-1:0]  pat_lo_q, pat_lo_d;
  logic [CFG_DATA_W-1:0]  pat_hi_q, pat_hi_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [HASH_W-1:0]      mod_q, mod_d;
  logic [HASH_W-1:0]      text_hash_q, text_hash_d;
  logic [HASH_W-1:0]      pattern_hash_q, pattern_hash_d;
  logic [HASH_W-1:0]      lead_pow_q, lead_pow_d;
  logic [COUNT_W-1:0]     bytes_seen_q, bytes_seen_d;
  logic [COUNT_W-1:0]     hits_q, hits_d;
  logic                   found_q, found_d;
  logic [BYTE_W-1:0]      byte_q, byte_d;
  logic [KW-1:0]          k_q, k_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_data_q, out_data_d;

  logic [HASH_W-1:0]         q_eff;
  logic [KW-1:0]             len_eff;
  logic [PAT_BYTES*BYTE_W-1:0] pat_all;
  logic [BYTE_W-1:0]         pat_win [MaxPattern];
  logic                      out_free;
  logic                      heq;
  logic                      match;

  modu_cmd_t          modu_cmd;
  logic [HASH_W-1:0]  modu_res;
  logic               modu_busy;
  win_cmd_t           win_cmd;
  logic [BYTE_W-1:0]  win_tail;
  logic               win_match;

  rhpm_modunit u_modunit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (modu_cmd),
    .q_i    (q_eff),
    .res_o  (modu_res),
    .busy_o (modu_busy)
  );

  rhpm_window #(
    .MaxPattern (MaxPattern)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (win_cmd),
    .len_i   (len_eff),
    .pat_i   (pat_win),
    .tail_o  (win_tail),
    .match_o (win_match)
  );

  // A zero modulus acts as one; the length is clamped to 1..MaxPattern.
  assign q_eff   = (mod_q == '0) ? HASH_W'(1) : mod_q;
  assign len_eff = (len_q == '0) ? KW'(1) :
                   (len_q > LEN_W'(MaxPattern)) ? KW'(MaxPattern) : len_q[KW-1:0];

  assign pat_all = {pat_hi_q, pat_lo_q};
  always_comb begin
    for (int unsigned j = 0; j < MaxPattern; j++) begin
      pat_win[j] = pat_all[BYTE_W*j +: BYTE_W];
    end
  end

  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign heq   = (text_hash_q == pattern_hash_q);
  assign match = heq && win_match;

  always_comb begin
    state_d        = state_q;
    pat_lo_d       = pat_lo_q;
    pat_hi_d       = pat_hi_q;
    len_d          = len_q;
    mod_d          = mod_q;
    text_hash_d    = text_hash_q;
    pattern_hash_d = pattern_hash_q;
    lead_pow_d     = lead_pow_q;
    bytes_seen_d   = bytes_seen_q;
    hits_d         = hits_q;
    found_d        = found_q;
    byte_d         = byte_q;
    k_d            = k_q;
    out_valid_d    = out_valid_q;
    out_data_d     = out_data_q;
    modu_cmd       = '0;
    win_cmd        = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          // Every index names a register; each write rederives the pattern.
          unique case (cfg_reg_e'(cfg_index_i))
            REG_PAT_LOW: begin
              pat_lo_d = cfg_data_i;
            end
            REG_PAT_HIGH: begin
              pat_hi_d = cfg_data_i;
            end
            REG_PAT_LEN: begin
              len_d        = cfg_data_i[LEN_W-1:0];
              text_hash_d  = '0;
              bytes_seen_d = '0;
              hits_d       = '0;
              found_d      = 1'b0;
              win_cmd.clear = 1'b1;
            end
            REG_MODULUS: begin
              mod_d        = cfg_data_i[HASH_W-1:0];
              text_hash_d  = '0;
              bytes_seen_d = '0;
              hits_d       = '0;
              found_d      = 1'b0;
              win_cmd.clear = 1'b1;
            end
            default: begin
            end
          endcase
          state_d = S_DER_INIT;
        end else if (in_valid_i) begin
          byte_d = in_data_i.text_byte;
          if (in_data_i.start_of_text) begin
            text_hash_d  = '0;
            bytes_seen_d = '0;
            hits_d       = '0;
            found_d      = 1'b0;
            win_cmd.clear = 1'b1;
          end
          state_d = S_ITEM;
        end
      end

      S_ITEM: begin
        modu_cmd.start = 1'b1;
        if (bytes_seen_q >= COUNT_W'(len_eff)) begin
          // Weight of the byte that leaves the window.
          modu_cmd.acc    = '0;
          modu_cmd.mult   = win_tail;
          modu_cmd.addend = lead_pow_q;
          state_d         = S_DROP_WAIT;
        end else begin
          modu_cmd.acc    = text_hash_q;
          modu_cmd.mult   = byte_q;
          modu_cmd.addend = HASH_W'(1);
          state_d         = S_UPD_WAIT;
        end
      end

      S_DROP_WAIT: begin
        if (!modu_busy) begin
          modu_cmd.start  = 1'b1;
          modu_cmd.sub    = 1'b1;
          modu_cmd.acc    = text_hash_q;
          modu_cmd.addend = modu_res;
          state_d         = S_SUB_WAIT;
        end
      end

      S_SUB_WAIT: begin
        // The subtract does not set busy, so the unit is free here.
        modu_cmd.start  = 1'b1;
        modu_cmd.acc    = modu_res;
        modu_cmd.mult   = byte_q;
        modu_cmd.addend = HASH_W'(1);
        state_d         = S_UPD_WAIT;
      end

      S_UPD_WAIT: begin
        if (!modu_busy) begin
          text_hash_d   = modu_res;
          win_cmd.shift = 1'b1;
          win_cmd.data  = byte_q;
          if (bytes_seen_q != '1) begin
            bytes_seen_d = bytes_seen_q + COUNT_W'(1);
          end
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (bytes_seen_q < COUNT_W'(len_eff)) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          hits_d  = (heq && (hits_q != '1)) ? hits_q + COUNT_W'(1) : hits_q;
          found_d = found_q || match;
          out_valid_d              = 1'b1;
          out_data_d.window_start  = bytes_seen_q - COUNT_W'(len_eff);
          out_data_d.hash_equal    = heq;
          out_data_d.pattern_match = match;
          out_data_d.hit_count     = (heq && (hits_q != '1)) ? hits_q + COUNT_W'(1) : hits_q;
          out_data_d.found_any     = found_q || match;
          state_d                  = S_IDLE;
        end
      end

      S_DER_INIT: begin
        k_d            = '0;
        pattern_hash_d = '0;
        lead_pow_d     = HASH_W'(q_eff != HASH_W'(1));
        state_d        = S_DER_P;
      end

      S_DER_P: begin
        modu_cmd.start  = 1'b1;
        modu_cmd.acc    = pattern_hash_q;
        modu_cmd.mult   = pat_win[k_q[IdxW-1:0]];
        modu_cmd.addend = HASH_W'(1);
        state_d         = S_DER_P_WAIT;
      end

      S_DER_P_WAIT: begin
        if (!modu_busy) begin
          pattern_hash_d = modu_res;
          if (k_q + KW'(1) == len_eff) begin
            k_d     = KW'(1);
            state_d = S_DER_H;
          end else begin
            k_d     = k_q + KW'(1);
            state_d = S_DER_P;
          end
        end
      end

      S_DER_H: begin
        if (k_q >= len_eff) begin
          state_d = S_IDLE;
        end else begin
          // A zero multiplier leaves only the eight doublings.
          modu_cmd.start  = 1'b1;
          modu_cmd.acc    = lead_pow_q;
          modu_cmd.mult   = '0;
          modu_cmd.addend = HASH_W'(1);
          state_d         = S_DER_H_WAIT;
        end
      end

      S_DER_H_WAIT: begin
        if (!modu_busy) begin
          lead_pow_d = modu_res;
          k_d        = k_q + KW'(1);
          state_d    = S_DER_H;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      pat_lo_q       <= '0;
      pat_hi_q       <= '0;
      len_q          <= LEN_RESET;
      mod_q          <= MODULUS_RESET;
      text_hash_q    <= '0;
      pattern_hash_q <= '0;
      lead_pow_q     <= HASH_W'(1);
      bytes_seen_q   <= '0;
      hits_q         <= '0;
      found_q        <= 1'b0;
      byte_q         <= '0;
      k_q            <= '0;
      out_valid_q    <= 1'b0;
      out_data_q     <= '0;
    end else begin
      state_q        <= state_d;
      pat_lo_q       <= pat_lo_d;
      pat_hi_q       <= pat_hi_d;
      len_q          <= len_d;
      mod_q          <= mod_d;
      text_hash_q    <= text_hash_d;
      pattern_hash_q <= pattern_hash_d;
      lead_pow_q     <= lead_pow_d;
      bytes_seen_q   <= bytes_seen_d;
      hits_q         <= hits_d;
      found_q        <= found_d;
      byte_q         <= byte_d;
      k_q            <= k_d;
      out_valid_q    <= out_valid_d;
      out_data_q     <= out_data_d;
    end
  end

  // The running text hash is always fully reduced.
  a_text_hash_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    text_hash_q < q_eff)
    else $error("text hash not below modulus");

  // Derived values are reduced whenever a new byte may be taken.
  a_derived_reduced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((pattern_hash_q < q_eff) && (lead_pow_q < q_eff)))
    else $error("pattern hash or leading power not below modulus");

  // Hits only come from full windows, so they never outnumber bytes.
  a_hits_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hits_q <= bytes_seen_q)
    else $error("hit count above byte count");

  // An exact match always follows a hash hit.
  a_found_needs_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (hits_q != '0))
    else $error("found flag set without any hash hit");

  // The sequencer never starts the shared unit while it is still stepping.
  a_unit_free_on_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    modu_cmd.start |-> !modu_busy)
    else $error("modular unit started while busy");

endmodule
